// ----- rtl/core/cpot_pkg.sv -----
// Package for the capsule pair overlap test unit.
// Holds the sequencer state codes, the operand and destination codes of the
// shared multiply-accumulate unit and its micro-program. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpot_pkg;

  localparam int DIST_W  = 34;
  localparam int LIMIT_W = 32;
  localparam int DIG_W   = 16;
  localparam int QFRAC   = 32;
  localparam int PC_W    = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd66;
  localparam logic [DIST_W-1:0]  DIST_MAX    = '1;

  // program counter landmarks
  localparam logic [PC_W-1:0] PC_DET_LAST   = 6'd20;
  localparam logic [PC_W-1:0] PC_COMP_FIRST = 6'd21;
  localparam logic [PC_W-1:0] PC_LAST       = 6'd33;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MAC   = 7'b0000010,
    ST_DEC1  = 7'b0000100,
    ST_DEC2  = 7'b0001000,
    ST_DINIT = 7'b0010000,
    ST_DITER = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [4:0] {
    OPD_U0, OPD_U1, OPD_U2,
    OPD_V0, OPD_V1, OPD_V2,
    OPD_W0, OPD_W1, OPD_W2,
    OPD_A, OPD_B, OPD_C, OPD_D, OPD_E,
    OPD_QS, OPD_QT, OPD_P32,
    OPD_C0, OPD_C1, OPD_C2,
    OPD_RS
  } opnd_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_A, DST_B, DST_C, DST_D, DST_E,
    DST_DET, DST_SN, DST_TN,
    DST_C0, DST_C1, DST_C2,
    DST_DIST, DST_RR
  } dst_t;

  typedef struct packed {
    opnd_t xs;
    opnd_t ys;
    logic  clr;
    logic  sub;
    dst_t  dst;
  } mac_op_t;

  function automatic mac_op_t mk_op(input opnd_t x, input opnd_t y, input logic c,
                                    input logic s, input dst_t d);
    mac_op_t op;
    op.xs  = x;
    op.ys  = y;
    op.clr = c;
    op.sub = s;
    op.dst = d;
    return op;
  endfunction

  // micro-program: dot products, determinant and numerators, then the
  // closest-point components, their squares and the squared radius sum
  function automatic mac_op_t prog_op(input logic [PC_W-1:0] pc);
    mac_op_t op;
    case (pc)
      6'd0:  op = mk_op(OPD_U0, OPD_U0, 1'b1, 1'b0, DST_NONE);
      6'd1:  op = mk_op(OPD_U1, OPD_U1, 1'b0, 1'b0, DST_NONE);
      6'd2:  op = mk_op(OPD_U2, OPD_U2, 1'b0, 1'b0, DST_A);
      6'd3:  op = mk_op(OPD_U0, OPD_V0, 1'b1, 1'b0, DST_NONE);
      6'd4:  op = mk_op(OPD_U1, OPD_V1, 1'b0, 1'b0, DST_NONE);
      6'd5:  op = mk_op(OPD_U2, OPD_V2, 1'b0, 1'b0, DST_B);
      6'd6:  op = mk_op(OPD_V0, OPD_V0, 1'b1, 1'b0, DST_NONE);
      6'd7:  op = mk_op(OPD_V1, OPD_V1, 1'b0, 1'b0, DST_NONE);
      6'd8:  op = mk_op(OPD_V2, OPD_V2, 1'b0, 1'b0, DST_C);
      6'd9:  op = mk_op(OPD_U0, OPD_W0, 1'b1, 1'b0, DST_NONE);
      6'd10: op = mk_op(OPD_U1, OPD_W1, 1'b0, 1'b0, DST_NONE);
      6'd11: op = mk_op(OPD_U2, OPD_W2, 1'b0, 1'b0, DST_D);
      6'd12: op = mk_op(OPD_V0, OPD_W0, 1'b1, 1'b0, DST_NONE);
      6'd13: op = mk_op(OPD_V1, OPD_W1, 1'b0, 1'b0, DST_NONE);
      6'd14: op = mk_op(OPD_V2, OPD_W2, 1'b0, 1'b0, DST_E);
      6'd15: op = mk_op(OPD_A,  OPD_C,  1'b1, 1'b0, DST_NONE);
      6'd16: op = mk_op(OPD_B,  OPD_B,  1'b0, 1'b1, DST_DET);
      6'd17: op = mk_op(OPD_B,  OPD_E,  1'b1, 1'b0, DST_NONE);
      6'd18: op = mk_op(OPD_C,  OPD_D,  1'b0, 1'b1, DST_SN);
      6'd19: op = mk_op(OPD_A,  OPD_E,  1'b1, 1'b0, DST_NONE);
      6'd20: op = mk_op(OPD_B,  OPD_D,  1'b0, 1'b1, DST_TN);
      6'd21: op = mk_op(OPD_W0, OPD_P32, 1'b1, 1'b0, DST_NONE);
      6'd22: op = mk_op(OPD_QS, OPD_U0, 1'b0, 1'b0, DST_NONE);
      6'd23: op = mk_op(OPD_QT, OPD_V0, 1'b0, 1'b1, DST_C0);
      6'd24: op = mk_op(OPD_W1, OPD_P32, 1'b1, 1'b0, DST_NONE);
      6'd25: op = mk_op(OPD_QS, OPD_U1, 1'b0, 1'b0, DST_NONE);
      6'd26: op = mk_op(OPD_QT, OPD_V1, 1'b0, 1'b1, DST_C1);
      6'd27: op = mk_op(OPD_W2, OPD_P32, 1'b1, 1'b0, DST_NONE);
      6'd28: op = mk_op(OPD_QS, OPD_U2, 1'b0, 1'b0, DST_NONE);
      6'd29: op = mk_op(OPD_QT, OPD_V2, 1'b0, 1'b1, DST_C2);
      6'd30: op = mk_op(OPD_C0, OPD_C0, 1'b1, 1'b0, DST_NONE);
      6'd31: op = mk_op(OPD_C1, OPD_C1, 1'b0, 1'b0, DST_NONE);
      6'd32: op = mk_op(OPD_C2, OPD_C2, 1'b0, 1'b0, DST_DIST);
      6'd33: op = mk_op(OPD_RS, OPD_RS, 1'b1, 1'b0, DST_RR);
      default: op = mk_op(OPD_U0, OPD_U0, 1'b1, 1'b0, DST_NONE);
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/capsule_pair_overlap_test_unit.sv -----
// A first capsule is taken and held. A second capsule runs 34 multiply-accumulate
// ops on one shared digit multiplier, each op stepping through the digits of |y|
// and then adding (NDIG = ceil((COORD_WIDTH+35)/16) digits, 4 at COORD_WIDTH=16):
// ops 0..20, the decision states DEC1 and DEC2 and two restoring divisions,
// then ops 21..33 and the output state.
// Reset: synchronous, clears the sequencer, held flag, output valid; limit=66.
// Top level of the capsule pair overlap test; uses cpot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module capsule_pair_overlap_test_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [COORD_WIDTH-1:0]     start_x,
  input  wire logic signed [COORD_WIDTH-1:0]     start_y,
  input  wire logic signed [COORD_WIDTH-1:0]     start_z,
  input  wire logic signed [COORD_WIDTH-1:0]     end_x,
  input  wire logic signed [COORD_WIDTH-1:0]     end_y,
  input  wire logic signed [COORD_WIDTH-1:0]     end_z,
  input  wire logic        [COORD_WIDTH-1:0]     radius,
  input  wire logic                              is_second,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [cpot_pkg::DIST_W-1:0]            distance_squared,
  output logic                                   hit,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cpot_pkg::LIMIT_W-1:0]      cfg_data
);

  localparam int EW    = COORD_WIDTH + 1;
  localparam int XW    = COORD_WIDTH + 35;
  localparam int DW    = 2 * COORD_WIDTH + 3;
  localparam int NDW   = DW + 1;
  localparam int NW    = 4 * COORD_WIDTH + 6;
  localparam int AW    = 2 * XW + 3;
  localparam int SQ_SH = 2 * cpot_pkg::QFRAC;
  localparam int RW    = AW - SQ_SH;
  localparam int RRW   = 2 * COORD_WIDTH + 2;
  localparam int PW    = 2 * XW;
  localparam int NDIG  = (XW + cpot_pkg::DIG_W - 1) / cpot_pkg::DIG_W;
  localparam int DCW   = $clog2(NDIG);
  localparam int QW    = cpot_pkg::QFRAC + 1;
  localparam int CYW   = $clog2(cpot_pkg::QFRAC);
  localparam int CMPW  = (RW > cpot_pkg::DIST_W) ? RW : cpot_pkg::DIST_W;
  localparam logic [QW-1:0] QONE = {1'b1, {cpot_pkg::QFRAC{1'b0}}};

  cpot_pkg::state_t state;
  logic have_first;
  logic [cpot_pkg::LIMIT_W-1:0] limit;

  logic signed [COORD_WIDTH-1:0] held_s [3];
  logic signed [COORD_WIDTH-1:0] held_e [3];
  logic        [COORD_WIDTH-1:0] held_r;
  logic signed [COORD_WIDTH-1:0] in_s [3];
  logic signed [COORD_WIDTH-1:0] in_e [3];

  logic signed [EW-1:0] u [3];
  logic signed [EW-1:0] v [3];
  logic signed [EW-1:0] w [3];
  logic [EW-1:0] rsum;

  logic [cpot_pkg::PC_W-1:0] pc;
  logic [DCW-1:0] dcnt;
  logic mphase;
  logic [PW-1:0] prod;
  logic [AW-1:0] acc;

  logic signed [DW-1:0] a_r, b_r, c_r, d_r, e_r;
  logic signed [NW-1:0] det, sn, tn;
  logic signed [NW-1:0] s_num, s_den, t_num, t_den;
  logic signed [XW-1:0] comp [3];
  logic [RW-1:0] dist_sq;
  logic [RRW-1:0] rr;

  logic dsel;
  logic [NW:0] rem;
  logic [cpot_pkg::QFRAC-1:0] qacc;
  logic [CYW-1:0] dcyc;
  logic [QW-1:0] qs, qt;

  logic in_acc, out_free;
  cpot_pkg::mac_op_t op;
  logic signed [XW-1:0] x_val, y_val;
  logic [XW-1:0] mx, my;
  logic [NDIG*cpot_pkg::DIG_W-1:0] my_pad;
  logic [cpot_pkg::DIG_W-1:0] dig;
  logic [XW+cpot_pkg::DIG_W-1:0] pp;
  logic [PW-1:0] prod_next;
  logic neg;
  logic [AW-1:0] prod_ext, addend, acc_base, acc_sum;
  logic [RW-1:0] rounded;

  logic signed [NW-1:0] lim_s, e_n, eb_n;
  logic signed [NDW-1:0] nd, a_nd;
  logic clamp_t;

  logic signed [NW-1:0] n_div, d_div;
  logic [NW:0] d_u, r2, rem_next;
  logic ge, n_pos, d_pos, div_fin;
  logic [QW-1:0] div_q;

  logic [CMPW-1:0] dist_ext;

  // operand select for the shared multiplier
  function automatic logic signed [XW-1:0] opnd_val(input cpot_pkg::opnd_t sel);
    logic signed [XW-1:0] r;
    case (sel)
      cpot_pkg::OPD_U0:  r = XW'(u[0]);
      cpot_pkg::OPD_U1:  r = XW'(u[1]);
      cpot_pkg::OPD_U2:  r = XW'(u[2]);
      cpot_pkg::OPD_V0:  r = XW'(v[0]);
      cpot_pkg::OPD_V1:  r = XW'(v[1]);
      cpot_pkg::OPD_V2:  r = XW'(v[2]);
      cpot_pkg::OPD_W0:  r = XW'(w[0]);
      cpot_pkg::OPD_W1:  r = XW'(w[1]);
      cpot_pkg::OPD_W2:  r = XW'(w[2]);
      cpot_pkg::OPD_A:   r = XW'(a_r);
      cpot_pkg::OPD_B:   r = XW'(b_r);
      cpot_pkg::OPD_C:   r = XW'(c_r);
      cpot_pkg::OPD_D:   r = XW'(d_r);
      cpot_pkg::OPD_E:   r = XW'(e_r);
      cpot_pkg::OPD_QS:  r = XW'(qs);
      cpot_pkg::OPD_QT:  r = XW'(qt);
      cpot_pkg::OPD_P32: r = XW'(QONE);
      cpot_pkg::OPD_C0:  r = comp[0];
      cpot_pkg::OPD_C1:  r = comp[1];
      cpot_pkg::OPD_C2:  r = comp[2];
      cpot_pkg::OPD_RS:  r = XW'(rsum);
      default:           r = '0;
    endcase
    return r;
  endfunction

  assign in_s[0] = start_x;
  assign in_s[1] = start_y;
  assign in_s[2] = start_z;
  assign in_e[0] = end_x;
  assign in_e[1] = end_y;
  assign in_e[2] = end_z;

  assign in_stall  = (state != cpot_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // multiply-accumulate datapath: one 16-bit digit of |y| per cycle, then add
  always_comb begin
    op        = cpot_pkg::prog_op(pc);
    x_val     = opnd_val(op.xs);
    y_val     = opnd_val(op.ys);
    mx        = x_val[XW-1] ? (~x_val + 1'b1) : x_val;
    my        = y_val[XW-1] ? (~y_val + 1'b1) : y_val;
    neg       = x_val[XW-1] ^ y_val[XW-1] ^ op.sub;
    my_pad    = (NDIG*cpot_pkg::DIG_W)'(my);
    dig       = my_pad[dcnt*cpot_pkg::DIG_W +: cpot_pkg::DIG_W];
    pp        = mx * dig;
    prod_next = {prod[PW-cpot_pkg::DIG_W-1:0], {cpot_pkg::DIG_W{1'b0}}} + PW'(pp);
    prod_ext  = AW'(prod);
    addend    = neg ? (~prod_ext + 1'b1) : prod_ext;
    acc_base  = op.clr ? '0 : acc;
    acc_sum   = acc_base + addend;
    rounded   = acc_sum[AW-1:SQ_SH] + RW'(acc_sum[SQ_SH-1]);
  end

  // parameter decisions
  always_comb begin
    lim_s   = NW'($signed({1'b0, limit}));
    e_n     = NW'(e_r);
    eb_n    = NW'(e_r) + NW'(b_r);
    clamp_t = t_num[NW-1] || (t_den < t_num);
    nd      = t_num[NW-1] ? -NDW'(d_r) : (NDW'(b_r) - NDW'(d_r));
    a_nd    = NDW'(a_r);
  end

  // restoring divider for the clamped parameters
  always_comb begin
    n_div    = dsel ? t_num : s_num;
    d_div    = dsel ? t_den : s_den;
    d_u      = {1'b0, d_div};
    r2       = {rem[NW-1:0], 1'b0};
    ge       = (r2 >= d_u);
    rem_next = ge ? (r2 - d_u) : r2;
    n_pos    = !n_div[NW-1] && (n_div != '0);
    d_pos    = !d_div[NW-1] && (d_div != '0);
    div_fin  = 1'b0;
    div_q    = '0;
    if (state == cpot_pkg::ST_DINIT) begin
      if (!(n_pos && d_pos)) begin
        div_fin = 1'b1;
      end else if (n_div >= d_div) begin
        div_fin = 1'b1;
        div_q   = QONE;
      end
    end else if (state == cpot_pkg::ST_DITER) begin
      div_fin = (dcyc == CYW'(cpot_pkg::QFRAC - 1));
      div_q   = {1'b0, qacc[cpot_pkg::QFRAC-2:0], ge};
    end
  end

  assign dist_ext = CMPW'(dist_sq);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= cpot_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cpot_pkg::ST_IDLE;
      have_first <= 1'b0;
    end else begin
      case (state)
        cpot_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (!is_second) begin
              have_first <= 1'b1;
            end else if (have_first) begin
              have_first <= 1'b0;
              state      <= cpot_pkg::ST_MAC;
            end
          end
        end
        cpot_pkg::ST_MAC: begin
          if (mphase) begin
            if (pc == cpot_pkg::PC_DET_LAST) begin
              state <= cpot_pkg::ST_DEC1;
            end else if (pc == cpot_pkg::PC_LAST) begin
              state <= cpot_pkg::ST_OUT;
            end
          end
        end
        cpot_pkg::ST_DEC1: state <= cpot_pkg::ST_DEC2;
        cpot_pkg::ST_DEC2: state <= cpot_pkg::ST_DINIT;
        cpot_pkg::ST_DINIT, cpot_pkg::ST_DITER: begin
          if (div_fin) begin
            state <= dsel ? cpot_pkg::ST_MAC : cpot_pkg::ST_DINIT;
          end else begin
            state <= cpot_pkg::ST_DITER;
          end
        end
        cpot_pkg::ST_OUT: begin
          if (out_free) begin
            state <= cpot_pkg::ST_IDLE;
          end
        end
        default: state <= cpot_pkg::ST_IDLE;
      endcase
    end
  end

  // capture capsules and build the difference vectors
  always_ff @(posedge clk) begin
    if (in_acc && !is_second) begin
      for (int k = 0; k < 3; k++) begin
        held_s[k] <= in_s[k];
        held_e[k] <= in_e[k];
      end
      held_r <= radius;
    end
    if (in_acc && is_second && have_first) begin
      for (int k = 0; k < 3; k++) begin
        u[k] <= EW'(held_e[k]) - EW'(held_s[k]);
        v[k] <= EW'(in_e[k]) - EW'(in_s[k]);
        w[k] <= EW'(held_s[k]) - EW'(in_s[k]);
      end
      rsum <= EW'(held_r) + EW'(radius);
    end
  end

  // program counter and digit sequencing of the shared unit
  always_ff @(posedge clk) begin
    if (state == cpot_pkg::ST_IDLE) begin
      pc     <= '0;
      dcnt   <= DCW'(NDIG - 1);
      mphase <= 1'b0;
      prod   <= '0;
    end else if (state == cpot_pkg::ST_MAC) begin
      if (!mphase) begin
        prod <= prod_next;
        if (dcnt == '0) begin
          mphase <= 1'b1;
        end else begin
          dcnt <= dcnt - 1'b1;
        end
      end else begin
        acc    <= acc_sum;
        pc     <= pc + 1'b1;
        dcnt   <= DCW'(NDIG - 1);
        mphase <= 1'b0;
        prod   <= '0;
      end
    end
  end

  // write back finished sums
  always_ff @(posedge clk) begin
    if (state == cpot_pkg::ST_MAC && mphase) begin
      case (op.dst)
        cpot_pkg::DST_A:    a_r     <= acc_sum[DW-1:0];
        cpot_pkg::DST_B:    b_r     <= acc_sum[DW-1:0];
        cpot_pkg::DST_C:    c_r     <= acc_sum[DW-1:0];
        cpot_pkg::DST_D:    d_r     <= acc_sum[DW-1:0];
        cpot_pkg::DST_E:    e_r     <= acc_sum[DW-1:0];
        cpot_pkg::DST_DET:  det     <= acc_sum[NW-1:0];
        cpot_pkg::DST_SN:   sn      <= acc_sum[NW-1:0];
        cpot_pkg::DST_TN:   tn      <= acc_sum[NW-1:0];
        cpot_pkg::DST_C0:   comp[0] <= acc_sum[XW-1:0];
        cpot_pkg::DST_C1:   comp[1] <= acc_sum[XW-1:0];
        cpot_pkg::DST_C2:   comp[2] <= acc_sum[XW-1:0];
        cpot_pkg::DST_DIST: dist_sq <= rounded;
        cpot_pkg::DST_RR:   rr      <= acc_sum[RRW-1:0];
        default: ;
      endcase
    end
  end

  // pick numerators and denominators, then clamp the second parameter and redo the first
  always_ff @(posedge clk) begin
    if (state == cpot_pkg::ST_DEC1) begin
      if (det <= lim_s) begin
        s_num <= '0;
        s_den <= NW'(1);
        t_num <= e_n;
        t_den <= NW'(c_r);
      end else if (sn[NW-1]) begin
        s_num <= '0;
        s_den <= det;
        t_num <= e_n;
        t_den <= NW'(c_r);
      end else if (det < sn) begin
        s_num <= det;
        s_den <= det;
        t_num <= eb_n;
        t_den <= NW'(c_r);
      end else begin
        s_num <= sn;
        s_den <= det;
        t_num <= tn;
        t_den <= det;
      end
    end else if (state == cpot_pkg::ST_DEC2 && clamp_t) begin
      t_num <= t_num[NW-1] ? '0 : t_den;
      if (nd[NDW-1]) begin
        s_num <= '0;
      end else if (nd > a_nd) begin
        s_num <= s_den;
      end else begin
        s_num <= NW'(nd);
        s_den <= NW'(a_r);
      end
    end
  end

  // divider iterations and parameter results
  always_ff @(posedge clk) begin
    if (state == cpot_pkg::ST_DEC2) begin
      dsel <= 1'b0;
    end
    if (state == cpot_pkg::ST_DINIT) begin
      rem  <= {1'b0, n_div};
      qacc <= '0;
      dcyc <= '0;
    end else if (state == cpot_pkg::ST_DITER) begin
      rem  <= rem_next;
      qacc <= {qacc[cpot_pkg::QFRAC-2:0], ge};
      dcyc <= dcyc + 1'b1;
    end
    if (div_fin) begin
      if (dsel) begin
        qt <= div_q;
      end else begin
        qs   <= div_q;
        dsel <= 1'b1;
      end
    end
  end

  // output register, saturate the distance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == cpot_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == cpot_pkg::ST_OUT && out_free) begin
      distance_squared <= (dist_ext > CMPW'(cpot_pkg::DIST_MAX)) ? cpot_pkg::DIST_MAX
                                                                 : dist_ext[cpot_pkg::DIST_W-1:0];
      hit <= (dist_sq <= RW'(rr));
    end
  end

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == cpot_pkg::ST_OUT))
    else $error("result transaction raised outside the output step");

  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    (state == cpot_pkg::ST_MAC && pc >= cpot_pkg::PC_COMP_FIRST) |->
      ((!qs[QW-1] || qs[QW-2:0] == '0) && (!qt[QW-1] || qt[QW-2:0] == '0)))
    else $error("segment parameter above one");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == cpot_pkg::ST_MAC) |-> (pc <= cpot_pkg::PC_LAST))
    else $error("program counter past last op");

  a_pair_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_second && have_first) |=> (!have_first && state == cpot_pkg::ST_MAC))
    else $error("pair did not start computation");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == cpot_pkg::ST_DITER) |-> (rem < d_u))
    else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire
